/* rtl/tdoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdoa_pkg: shared types and constants of the TDOA hyperbola locator
// Register map, result field widths, region codes and fixed-point constants.
// ----------------------------------------------------------------------------
package tdoa_pkg;

    localparam int POS_W    = 24;
    localparam int REGION_W = 3;
    localparam int PADDR_W  = 4;
    localparam int DPT_W    = 16;
    localparam int HD_W     = 20;
    localparam int TOL_RW   = 20;

    typedef logic [REGION_W-1:0] t_region;
    typedef logic [1:0]          t_cfg_idx;

    // register indexes (byte address / 4)
    localparam t_cfg_idx CFG_DPT = 2'd0;
    localparam t_cfg_idx CFG_HD  = 2'd1;
    localparam t_cfg_idx CFG_TOL = 2'd2;

    localparam logic [DPT_W-1:0]  DPT_RESET = 16'd22282;
    localparam logic [HD_W-1:0]   HD_RESET  = 20'd32583;
    localparam logic [TOL_RW-1:0] TOL_RESET = 20'd2560;

    localparam t_region REGION_NONE   = 3'd0;
    localparam t_region REGION_MIC1   = 3'd1;
    localparam t_region REGION_MIC2   = 3'd2;
    localparam t_region REGION_MIC3   = 3'd3;
    localparam t_region REGION_MIC4   = 3'd4;
    localparam t_region REGION_ORIGIN = 3'd5;

    // sqrt(2)/2 in Q0.16
    localparam logic [15:0] SQRT_HALF_Q16 = 16'd46341;
    // clamp of a half distance
    localparam logic [21:0] A_CLAMP = 22'h200000;
    // saturation of a squared coordinate
    localparam logic [62:0] SQ_SAT = 63'h4000000000000000;

endpackage

/* rtl/tdoa_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdoa_in_if: request channel of the TDOA locator
// Carries the four arrival timestamps with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdoa_in_if #(parameter int TICK_BITS = 16) ();
    logic                 valid;
    logic                 ready;
    logic [TICK_BITS-1:0] arrival_one;
    logic [TICK_BITS-1:0] arrival_two;
    logic [TICK_BITS-1:0] arrival_three;
    logic [TICK_BITS-1:0] arrival_four;

    modport source (output valid, arrival_one, arrival_two, arrival_three, arrival_four,
                    input ready);
    modport sink   (input valid, arrival_one, arrival_two, arrival_three, arrival_four,
                    output ready);
endinterface

/* rtl/tdoa_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdoa_out_if: result channel of the TDOA locator
// Carries position, solution flag and region code with valid/ready.
// ----------------------------------------------------------------------------
interface tdoa_out_if import tdoa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    solution_valid;
    t_region                 region_code;

    modport source (output valid, pos_x, pos_y, solution_valid, region_code, input ready);
    modport sink   (input valid, pos_x, pos_y, solution_valid, region_code, output ready);
endinterface

/* rtl/tdoa_hyperbola_locator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdoa_hyperbola_locator: four-microphone TDOA source locator
// Intersects the two diagonal hyperbolas with one shared shift-add
// multiplier, a restoring divider and a digit-by-digit square root.
// ----------------------------------------------------------------------------
//  channel  | port    | dir | contents
//  ---------+---------+-----+---------------------------------------------
//  request  | i_req   | in  | arrival_one .. arrival_four (TICK_BITS ticks)
//  result   | o_rsp   | out | pos_x, pos_y, solution_valid, region_code
//  config   | APB     | in  | distance_per_tick, half_diagonal, origin_tol
//
//  The time one request takes is set by the shift-add multiplier (one
//  multiplier bit a cycle), the two 128-step divisions and the two 32-step
//  square roots, and is shorter when the hyperbolas do not meet.
//  i_req.ready is high only while the sequencer is idle. A finished
//  result waits in the output register; the sequencer stalls before writing
//  a new one until the old one is taken. Reset (synchronous, active low)
//  restores the register defaults and clears the held position.
// ----------------------------------------------------------------------------
module tdoa_hyperbola_locator import tdoa_pkg::*; #(
    parameter int TICK_BITS = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tdoa_in_if.sink            i_req,
    tdoa_out_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int PW    = TICK_BITS + 16;        // |d| * distance_per_tick
    localparam int RND   = 16 - FRAC_BITS;        // rounding bit of the half distance
    localparam int TOL_W = TOL_RW + RND;          // scaled origin tolerance
    localparam int CW    = (PW > TOL_W) ? PW : TOL_W;
    localparam int ACC_W = 128;
    localparam int MC_W  = 80;
    localparam int ML_W  = 41;
    localparam int SW    = 45;                    // sums of squares

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL, S_STORE, S_HALF, S_CHECK, S_DIV, S_SQRT, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        J_P1, J_P2, J_A1, J_A2, J_C, J_DEN, J_TX, J_NX, J_TY, J_NY, J_RX, J_RY
    } t_job;

    t_state r_state;
    t_job   r_job;
    logic   r_pass;     // 0 while working on x, 1 on y

    // configuration
    logic [DPT_W-1:0]  r_dpt;
    logic [HD_W-1:0]   r_hd;
    logic [TOL_RW-1:0] r_tol;

    // request operands
    logic [TICK_BITS-1:0] r_t [4];
    logic [TICK_BITS-1:0] r_d1, r_d2;
    logic                 r_n1, r_n2;

    // intermediate results
    logic [PW-1:0] r_p1, r_p2;
    logic [21:0]   r_a1, r_a2;
    logic [43:0]   r_sq1, r_sq2;
    logic [39:0]   r_csq;
    logic [79:0]   r_den, r_tmp;
    logic [31:0]   r_dx, r_dy;
    logic          r_sol;
    t_region       r_region;

    // shift-add multiplier
    logic [ACC_W-1:0] r_acc, r_mcand;
    logic [ML_W-1:0]  r_mplier;

    // divider
    logic [ACC_W-1:0] r_num;
    logic [79:0]      r_rem;
    logic [63:0]      r_q;
    logic             r_ovf;
    logic [6:0]       r_cnt;

    // square root
    logic [62:0] r_sv, r_sres, r_sbit;

    // held and delivered position
    logic signed [POS_W-1:0] r_held_x, r_held_y;
    logic signed [POS_W-1:0] r_pos_x, r_pos_y;
    logic                    r_ovalid, r_osol;
    t_region                 r_oregion;

    logic                    n_cfg_wr;
    logic [TICK_BITS:0]      n_diff1, n_diff2;
    logic [MC_W-1:0]         n_mcand;
    logic [ML_W-1:0]         n_mplier;
    logic [PW:0]             n_araw1, n_araw2;
    logic [21:0]             n_a1, n_a2;
    logic [SW-1:0]           n_sum, n_cmab, n_ca2, n_ca1, n_cma_pb, n_cmb_pa;
    logic                    n_meet;
    logic [CW-1:0]           n_tol_sh;
    t_region                 n_region;
    logic [80:0]             n_rem_sh, n_rem_sub;
    logic                    n_dge;
    logic [63:0]             n_q;
    logic                    n_ovf;
    logic [62:0]             n_sqin, n_ssum, n_sres;
    logic                    n_sge;
    logic signed [33:0]      n_sdx, n_sdy, n_sx, n_sy, n_srot;
    logic [32:0]             n_mag_x, n_mag_y;
    logic [48:0]             n_rnd;
    logic signed [POS_W-1:0] n_rot;

    function automatic logic signed [POS_W-1:0] rot_sat(input logic neg,
                                                        input logic [32:0] p);
        logic [POS_W-1:0] m;
        begin
            m = (p > 33'(SQ_SAT[62:39])) ? POS_W'(SQ_SAT[62:39]) : p[POS_W-1:0];
            if (neg) begin
                rot_sat = -$signed(m);
            end else if (m[POS_W-1]) begin
                rot_sat = {1'b0, {(POS_W-1){1'b1}}};
            end else begin
                rot_sat = $signed(m);
            end
        end
    endfunction

    // ---------------- handshake and configuration port ----------------
    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.pos_x          = r_pos_x;
    assign o_rsp.pos_y          = r_pos_y;
    assign o_rsp.solution_valid = r_osol;
    assign o_rsp.region_code    = r_oregion;

    assign pready   = 1'b1;
    assign n_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            CFG_DPT: prdata = {16'd0, r_dpt};
            CFG_HD:  prdata = {12'd0, r_hd};
            CFG_TOL: prdata = {12'd0, r_tol};
            default: prdata = '0;
        endcase
    end

    // ---------------- datapath helpers ----------------
    // signed tick differences of the diagonals, straight from the request
    assign n_diff1 = {1'b0, i_req.arrival_three} - {1'b0, i_req.arrival_one};
    assign n_diff2 = {1'b0, i_req.arrival_four} - {1'b0, i_req.arrival_two};

    // half distance: round, drop to Q.F and clamp
    assign n_araw1 = ({1'b0, r_p1} + ((PW + 1)'(1) << RND)) >> (RND + 1);
    assign n_araw2 = ({1'b0, r_p2} + ((PW + 1)'(1) << RND)) >> (RND + 1);
    assign n_a1    = (n_araw1 > (PW + 1)'(A_CLAMP)) ? A_CLAMP : n_araw1[21:0];
    assign n_a2    = (n_araw2 > (PW + 1)'(A_CLAMP)) ? A_CLAMP : n_araw2[21:0];

    // B1 B2 - A1 A2 = C (C - A1 - A2): the hyperbolas meet iff A1 + A2 < C
    assign n_sum    = SW'(r_sq1) + SW'(r_sq2);
    assign n_meet   = n_sum < SW'(r_csq);
    assign n_cmab   = SW'(r_csq) - n_sum;
    assign n_ca2    = SW'(r_csq) - SW'(r_sq2);
    assign n_ca1    = SW'(r_csq) - SW'(r_sq1);
    assign n_cma_pb = SW'(r_csq) - SW'(r_sq1) + SW'(r_sq2);
    assign n_cmb_pa = SW'(r_csq) - SW'(r_sq2) + SW'(r_sq1);

    // signed coordinates before the 45 degree turn; zero counts as positive
    assign n_sdx   = r_n1 ? -$signed({2'b00, r_dx}) : $signed({2'b00, r_dx});
    assign n_sdy   = r_n2 ? -$signed({2'b00, r_dy}) : $signed({2'b00, r_dy});
    assign n_sx    = n_sdx - n_sdy;
    assign n_sy    = n_sdx + n_sdy;
    assign n_mag_x = n_sx[33] ? 33'(-n_sx) : n_sx[32:0];
    assign n_mag_y = n_sy[33] ? 33'(-n_sy) : n_sy[32:0];

    // multiplier operand selection per job
    always_comb begin
        unique case (r_job)
            J_P1:    begin n_mcand = MC_W'(r_d1);    n_mplier = ML_W'(r_dpt);         end
            J_P2:    begin n_mcand = MC_W'(r_d2);    n_mplier = ML_W'(r_dpt);         end
            J_A1:    begin n_mcand = MC_W'(r_a1);    n_mplier = ML_W'(r_a1);          end
            J_A2:    begin n_mcand = MC_W'(r_a2);    n_mplier = ML_W'(r_a2);          end
            J_C:     begin n_mcand = MC_W'(r_hd);    n_mplier = ML_W'(r_hd);          end
            J_DEN:   begin n_mcand = MC_W'(r_csq);   n_mplier = n_cmab[ML_W-1:0];     end
            J_TX:    begin n_mcand = MC_W'(r_sq1);   n_mplier = n_ca2[ML_W-1:0];      end
            J_NX:    begin n_mcand = r_tmp;          n_mplier = n_cma_pb[ML_W-1:0];   end
            J_TY:    begin n_mcand = MC_W'(r_sq2);   n_mplier = n_ca1[ML_W-1:0];      end
            J_NY:    begin n_mcand = r_tmp;          n_mplier = n_cmb_pa[ML_W-1:0];   end
            J_RX:    begin n_mcand = MC_W'(n_mag_x); n_mplier = ML_W'(SQRT_HALF_Q16); end
            J_RY:    begin n_mcand = MC_W'(n_mag_y); n_mplier = ML_W'(SQRT_HALF_Q16); end
            default: begin n_mcand = '0;             n_mplier = '0;                   end
        endcase
    end

    // rotation result: round half away from zero, saturate
    assign n_srot = (r_job == J_RX) ? n_sx : n_sy;
    assign n_rnd  = r_acc[48:0] + 49'd32768;
    assign n_rot  = rot_sat(n_srot[33], n_rnd[48:16]);

    // region: strictly first microphone, else near origin
    assign n_tol_sh = CW'(r_tol) << RND;
    always_comb begin
        n_region = REGION_NONE;
        if (r_dpt != '0) begin
            if (r_t[0] < r_t[1] && r_t[0] < r_t[2] && r_t[0] < r_t[3]) begin
                n_region = REGION_MIC1;
            end else if (r_t[1] < r_t[0] && r_t[1] < r_t[2] && r_t[1] < r_t[3]) begin
                n_region = REGION_MIC2;
            end else if (r_t[2] < r_t[0] && r_t[2] < r_t[1] && r_t[2] < r_t[3]) begin
                n_region = REGION_MIC3;
            end else if (r_t[3] < r_t[0] && r_t[3] < r_t[1] && r_t[3] < r_t[2]) begin
                n_region = REGION_MIC4;
            end
        end
        if (n_region == REGION_NONE && CW'(r_p1) <= n_tol_sh && CW'(r_p2) <= n_tol_sh) begin
            n_region = REGION_ORIGIN;
        end
    end

    // restoring division step: one quotient bit a cycle
    assign n_rem_sh  = {r_rem, r_num[ACC_W-1]};
    assign n_dge     = n_rem_sh >= {1'b0, r_den};
    assign n_rem_sub = n_rem_sh - {1'b0, r_den};
    assign n_q       = {r_q[62:0], n_dge};
    assign n_ovf     = r_ovf | r_q[63];
    assign n_sqin    = (n_ovf || n_q > 64'(SQ_SAT)) ? SQ_SAT : n_q[62:0];

    // square root step: one result bit a cycle
    assign n_ssum = r_sres + r_sbit;
    assign n_sge  = r_sv >= n_ssum;
    assign n_sres = n_sge ? ((r_sres >> 1) + r_sbit) : (r_sres >> 1);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_job     <= J_P1;
            r_pass    <= 1'b0;
            r_dpt     <= DPT_RESET;
            r_hd      <= HD_RESET;
            r_tol     <= TOL_RESET;
            r_held_x  <= '0;
            r_held_y  <= '0;
            r_ovalid  <= 1'b0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_osol    <= 1'b0;
            r_oregion <= REGION_NONE;
        end else begin
            if (n_cfg_wr) begin
                unique case (paddr[3:2])
                    CFG_DPT: r_dpt <= pwdata[DPT_W-1:0];
                    CFG_HD:  r_hd  <= pwdata[HD_W-1:0];
                    CFG_TOL: r_tol <= pwdata[TOL_RW-1:0];
                    default: ;
                endcase
            end

            // drop the result once taken, unless a new one replaces it now
            if (r_ovalid && o_rsp.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_t[0] <= i_req.arrival_one;
                        r_t[1] <= i_req.arrival_two;
                        r_t[2] <= i_req.arrival_three;
                        r_t[3] <= i_req.arrival_four;
                        r_n1   <= n_diff1[TICK_BITS];
                        r_n2   <= n_diff2[TICK_BITS];
                        r_d1   <= n_diff1[TICK_BITS] ? TICK_BITS'(-n_diff1)
                                                     : n_diff1[TICK_BITS-1:0];
                        r_d2   <= n_diff2[TICK_BITS] ? TICK_BITS'(-n_diff2)
                                                     : n_diff2[TICK_BITS-1:0];
                        r_pass <= 1'b0;
                        r_job  <= J_P1;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_acc    <= '0;
                    r_mcand  <= ACC_W'(n_mcand);
                    r_mplier <= n_mplier;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    if (r_mplier == '0) begin
                        r_state <= S_STORE;
                    end else begin
                        if (r_mplier[0]) begin
                            r_acc <= r_acc + r_mcand;
                        end
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                S_STORE: begin
                    unique case (r_job)
                        J_P1: begin
                            r_p1 <= r_acc[PW-1:0]; r_job <= J_P2; r_state <= S_LOAD;
                        end
                        J_P2: begin r_p2 <= r_acc[PW-1:0]; r_state <= S_HALF; end
                        J_A1: begin
                            r_sq1 <= r_acc[43:0]; r_job <= J_A2; r_state <= S_LOAD;
                        end
                        J_A2: begin
                            r_sq2 <= r_acc[43:0]; r_job <= J_C; r_state <= S_LOAD;
                        end
                        J_C:  begin r_csq <= r_acc[39:0]; r_state <= S_CHECK; end
                        J_DEN: begin
                            r_den <= r_acc[79:0]; r_job <= J_TX; r_state <= S_LOAD;
                        end
                        J_TX: begin
                            r_tmp <= r_acc[79:0]; r_job <= J_NX; r_state <= S_LOAD;
                        end
                        J_TY: begin
                            r_tmp <= r_acc[79:0]; r_job <= J_NY; r_state <= S_LOAD;
                        end
                        J_NX, J_NY: begin
                            r_num   <= r_acc;
                            r_rem   <= '0;
                            r_q     <= '0;
                            r_ovf   <= 1'b0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                        J_RX: begin
                            r_held_x <= n_rot; r_job <= J_RY; r_state <= S_LOAD;
                        end
                        J_RY: begin r_held_y <= n_rot; r_state <= S_OUT; end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_HALF: begin
                    r_a1    <= n_a1;
                    r_a2    <= n_a2;
                    r_job   <= J_A1;
                    r_state <= S_LOAD;
                end
                S_CHECK: begin
                    r_region <= n_region;
                    r_sol    <= n_meet;
                    if (n_meet) begin
                        r_job   <= J_DEN;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    r_rem <= n_dge ? n_rem_sub[79:0] : n_rem_sh[79:0];
                    r_num <= r_num << 1;
                    r_q   <= n_q;
                    r_ovf <= n_ovf;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) begin
                        r_sv    <= n_sqin;
                        r_sres  <= '0;
                        r_sbit  <= SQ_SAT;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (n_sge) begin
                        r_sv <= r_sv - n_ssum;
                    end
                    r_sres <= n_sres;
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit[0]) begin
                        r_state <= S_LOAD;
                        if (!r_pass) begin
                            r_dx   <= n_sres[31:0];
                            r_pass <= 1'b1;
                            r_job  <= J_TY;
                        end else begin
                            r_dy  <= n_sres[31:0];
                            r_job <= J_RX;
                        end
                    end
                end
                S_OUT: begin
                    // hold until the previous result has left
                    if (!r_ovalid || o_rsp.ready) begin
                        r_pos_x   <= r_held_x;
                        r_pos_y   <= r_held_y;
                        r_osol    <= r_sol;
                        r_oregion <= r_region;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/tdoa_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdoa_chk: port checker of the TDOA locator
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module tdoa_chk import tdoa_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [POS_W-1:0] i_pos_x,
    input logic signed [POS_W-1:0] i_pos_y,
    input logic                    i_sol_valid,
    input t_region                 i_region
);

    logic signed [POS_W-1:0] r_last_x, r_last_y;

    // track the last delivered position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_x <= i_pos_x;
            r_last_y <= i_pos_y;
        end
    end

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while a previous one is in work");

    a_region_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_region <= REGION_ORIGIN)
        else $error("region code out of range");

    a_hold_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_sol_valid |-> i_pos_x == r_last_x && i_pos_y == r_last_y)
        else $error("position changed without a solution");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pos_x) && $stable(i_pos_y))
        else $error("stalled result changed");

endmodule

bind tdoa_hyperbola_locator tdoa_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_pos_x     (o_rsp.pos_x),
    .i_pos_y     (o_rsp.pos_y),
    .i_sol_valid (o_rsp.solution_valid),
    .i_region    (o_rsp.region_code)
);

/* sim/tdoa_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdoa_result_checker: locator prediction and result comparison
// Watches the request, result and register-write traffic of the locator,
// computes the expected position, flag and region of each request, and
// compares every returned result with the oldest expectation.
// ----------------------------------------------------------------------------
module tdoa_result_checker import tdoa_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdoa_in_if            req_mon,
    tdoa_out_if           rsp_mon,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic          pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]   pwdata,
    output int            o_errors,
    output int            o_pending
);

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    solution_valid;
        t_region                 region_code;
    } t_fix;

    t_fix                    fix_q[$];
    logic [DPT_W-1:0]        dist_per_tick;
    logic [HD_W-1:0]         half_diag;
    logic [TOL_RW-1:0]       origin_tol;
    logic signed [POS_W-1:0] last_x, last_y;

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned half_dist(input longint d);
        longint unsigned a;
        a = (magnitude(d) * longint'(dist_per_tick) + 256) >> 9;
        return (a > 64'(A_CLAMP)) ? 64'(A_CLAMP) : a;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root, probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Scale by sqrt(2)/2, round half away from zero, saturate to 24 bits.
    function automatic logic signed [POS_W-1:0] rotate45(input longint s);
        longint p;
        p = longint'((magnitude(s) * 64'(SQRT_HALF_Q16) + 32768) >> 16);
        if (p > 8388608) p = 8388608;
        if (s < 0) p = -p;
        if (p > 8388607) p = 8388607;
        return p[POS_W-1:0];
    endfunction

    function automatic logic [127:0] sq_coord(input logic [127:0] a_own, a_oth, cc);
        logic [127:0] num, den, q;
        num = a_own * (cc - a_oth) * (cc - a_own + a_oth);
        den = cc * (cc - a_own - a_oth);
        q = num / den;
        return (q > 128'(SQ_SAT)) ? 128'(SQ_SAT) : q;
    endfunction

    // Predict one result; updates the held position when a solution exists.
    function automatic t_fix locate(input logic [15:0] t1, t2, t3, t4);
        t_fix           f;
        longint         tk[4];
        longint         d31, d42, dx, dy;
        longint unsigned a1, a2, tol;
        logic [127:0]   sa1, sa2, cc;
        bit             first;
        tk[0] = t1; tk[1] = t2; tk[2] = t3; tk[3] = t4;
        d31 = tk[2] - tk[0];
        d42 = tk[3] - tk[1];
        a1 = half_dist(d31);
        a2 = half_dist(d42);
        sa1 = 128'(a1) * 128'(a1);
        sa2 = 128'(a2) * 128'(a2);
        cc  = 128'(half_diag) * 128'(half_diag);
        f.solution_valid = 1'b0;
        if (sa1 + sa2 < cc) begin
            dx = longint'(floor_sqrt(64'(sq_coord(sa1, sa2, cc))));
            dy = longint'(floor_sqrt(64'(sq_coord(sa2, sa1, cc))));
            // a zero difference counts as positive
            if (d31 < 0) dx = -dx;
            if (d42 < 0) dy = -dy;
            last_x = rotate45(dx - dy);
            last_y = rotate45(dx + dy);
            f.solution_valid = 1'b1;
        end
        f.pos_x = last_x;
        f.pos_y = last_y;
        f.region_code = REGION_NONE;
        if (dist_per_tick != 0) begin
            for (int k = 0; k < 4; k++) begin
                first = 1'b1;
                for (int j = 0; j < 4; j++)
                    if (j != k && !(tk[k] < tk[j])) first = 1'b0;
                if (first && f.region_code == REGION_NONE)
                    f.region_code = t_region'(k + 1);
            end
        end
        if (f.region_code == REGION_NONE) begin
            tol = 64'(origin_tol) << 8;
            if (magnitude(d31) * dist_per_tick <= tol &&
                magnitude(d42) * dist_per_tick <= tol)
                f.region_code = REGION_ORIGIN;
        end
        return f;
    endfunction

    assign o_pending = fix_q.size();

    always @(posedge i_clk) begin
        t_fix want;
        if (!i_rst_n) begin
            dist_per_tick <= DPT_RESET;
            half_diag     <= HD_RESET;
            origin_tol    <= TOL_RESET;
            last_x = '0;
            last_y = '0;
            fix_q.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_cfg_idx'(paddr >> 2))
                    CFG_DPT: dist_per_tick <= pwdata[DPT_W-1:0];
                    CFG_HD:  half_diag     <= pwdata[HD_W-1:0];
                    CFG_TOL: origin_tol    <= pwdata[TOL_RW-1:0];
                    default: ;
                endcase
            end
            if (req_mon.valid && req_mon.ready)
                fix_q.push_back(locate(req_mon.arrival_one, req_mon.arrival_two,
                                       req_mon.arrival_three, req_mon.arrival_four));
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (fix_q.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d", $time,
                             rsp_mon.pos_x, rsp_mon.pos_y);
                    o_errors <= o_errors + 1;
                end else begin
                    want = fix_q.pop_front();
                    if (want.pos_x !== rsp_mon.pos_x || want.pos_y !== rsp_mon.pos_y ||
                        want.solution_valid !== rsp_mon.solution_valid ||
                        want.region_code !== rsp_mon.region_code) begin
                        $display("%0t: mismatch expected x=%0d y=%0d v=%0b r=%0d",
                                 $time, want.pos_x, want.pos_y, want.solution_valid,
                                 want.region_code);
                        $display("%0t:            actual x=%0d y=%0d v=%0b r=%0d",
                                 $time, rsp_mon.pos_x, rsp_mon.pos_y,
                                 rsp_mon.solution_valid, rsp_mon.region_code);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* sim/tb_tdoa_hyperbola_locator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tdoa_hyperbola_locator: testbench of the TDOA hyperbola locator
// Drives directed and random timestamp requests under several register
// settings and idle patterns; a checker beside the block predicts and
// compares every result. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module tb_tdoa_hyperbola_locator;
    import tdoa_pkg::*;

    localparam int IDLE_LIMIT  = 60000; // cycles with no handshake before giving up
    localparam int SETTLE      = 700;   // longer than the slowest request
    localparam int ITEMS_PHASE = 190;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 errors, pending;
    int                 gap_pct = 0;   // sender idle chance, percent per cycle
    int                 stall_pct = 0; // receiver stall chance
    int                 quiet_cycles = 0;
    int                 span;          // tick difference that still gives a solution

    tdoa_in_if #(.TICK_BITS(16)) req_if ();
    tdoa_out_if                  rsp_if ();

    tdoa_hyperbola_locator #(.TICK_BITS(16), .FRAC_BITS(8)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    tdoa_result_checker i_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .req_mon  (req_if),
        .rsp_mon  (rsp_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .o_errors (errors),
        .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_if.valid = 1'b0;
        req_if.arrival_one = '0;
        req_if.arrival_two = '0;
        req_if.arrival_three = '0;
        req_if.arrival_four = '0;
        rsp_if.ready = 1'b0;
    end

    // Stall the result side at random according to the current phase.
    always @(posedge i_clk) rsp_if.ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_tdoa_hyperbola_locator: FAIL");
            $finish;
        end
    end

    // Write one register: setup cycle, then access cycle.
    task automatic reg_write(input t_cfg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send one request; hold valid high across back-to-back requests.
    task automatic send_arrivals(input logic [15:0] t1, t2, t3, t4);
        if ($urandom_range(99) < gap_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        req_if.valid         <= 1'b1;
        req_if.arrival_one   <= t1;
        req_if.arrival_two   <= t2;
        req_if.arrival_three <= t3;
        req_if.arrival_four  <= t4;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] dpt, input logic [19:0] hd, tol);
        logic [63:0] lim;
        reg_write(CFG_DPT, 32'(dpt));
        reg_write(CFG_HD,  32'(hd));
        reg_write(CFG_TOL, 32'(tol));
        lim  = (64'(hd) * 512) / dpt;
        span = (lim > 65535) ? 65535 : int'(lim);
    endtask

    function automatic logic [15:0] offset_tick(input logic [15:0] base, input int d);
        int v;
        v = int'(base) + d;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    // Mostly pairs inside the solution range, some ties, some plain noise.
    task automatic random_request();
        logic [15:0] t1, t2;
        int          lim, pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            send_arrivals(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            lim = (pick < 25) ? 8 : span;
            t1 = 16'($urandom);
            t2 = 16'($urandom);
            if (pick < 25 && $urandom_range(1)) t2 = t1;
            send_arrivals(t1, t2,
                          offset_tick(t1, $urandom_range(2 * lim) - lim),
                          offset_tick(t2, $urandom_range(2 * lim) - lim));
        end
    endtask

    initial begin
        span = 748;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset register values.
        send_arrivals(16'd0, 16'd0, 16'd0, 16'd0);             // origin, zero differences
        send_arrivals(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_arrivals(16'd100, 16'd200, 16'd200, 16'd200);     // mic one first
        send_arrivals(16'd300, 16'd100, 16'd300, 16'd300);     // mic two first
        send_arrivals(16'd500, 16'd500, 16'd400, 16'd500);     // mic three first
        send_arrivals(16'd500, 16'd500, 16'd500, 16'd499);     // mic four first
        send_arrivals(16'd100, 16'd100, 16'd200, 16'd200);     // tie for first
        send_arrivals(16'd1000, 16'd1000, 16'd1400, 16'd700);  // opposite signs
        send_arrivals(16'd1400, 16'd700, 16'd1000, 16'd1000);
        send_arrivals(16'd1000, 16'd1000, 16'd1000, 16'd1500); // one zero difference
        send_arrivals(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);       // no intersection
        send_arrivals(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_arrivals(16'd1000, 16'd1000, 16'd1059, 16'd1000); // beyond the origin tolerance
        send_arrivals(16'd1000, 16'd1000, 16'd1058, 16'd942);
        send_arrivals(16'd2000, 16'd2000, 16'd2700, 16'd2000); // close to the asymptote
        send_arrivals(16'd2000, 16'd2000, 16'd1500, 16'd2500);
        // Pause until every result is back before the register changes.
        drain();

        configure(16'hFFFF, 20'hFFFFF, 20'd0);
        send_arrivals(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_arrivals(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);       // no intersection, position held
        send_arrivals(16'd0, 16'd0, 16'd1, 16'd0);
        send_arrivals(16'd7, 16'd7, 16'd7, 16'd7);             // origin at zero tolerance
        drain();

        configure(16'd1, 20'd1, 20'hFFFFF);
        send_arrivals(16'd5, 16'd5, 16'd5, 16'd5);
        send_arrivals(16'd0, 16'd9, 16'hFFFF, 16'd0);
        drain();

        // Random phases: register settings and idle patterns both rotate.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure(DPT_RESET, HD_RESET, TOL_RESET);
                1: configure(16'hFFFF, 20'hFFFFF, 20'd0);
                2: configure(16'd1, 20'hFFFFF, 20'hFFFFF);
                3: configure(16'd1, 20'd1, 20'd0);
                default: configure(16'($urandom_range(65535, 1)),
                                   20'($urandom_range(1048575, 1)),
                                   20'($urandom_range(1048575)));
            endcase
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 76; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 76; end
                default: begin gap_pct = 24; stall_pct = 24; end
            endcase
            repeat (ITEMS_PHASE) random_request();
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("tb_tdoa_hyperbola_locator: PASS");
        end else begin
            $display("tb_tdoa_hyperbola_locator: FAIL");
        end
        $finish;
    end

endmodule
